// File: sv/quicksort_lomuto_engine_assert.svh
// Assertion helpers used by the checker file
`ifndef QUICKSORT_LOMUTO_ENGINE_ASSERT_SVH
`define QUICKSORT_LOMUTO_ENGINE_ASSERT_SVH

// Same-cycle implication
`define QLE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define QLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/qle_pkg.sv
package qle_pkg;

  localparam int MAX_KEYS = 64;
  localparam int IDX_W    = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int KEY_W    = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic                    last_out;
  } out_item_t;

  // Pending range on the stack
  typedef struct packed {
    idx_t lo;
    idx_t hi;
  } range_t;

  // Key memory read address source
  typedef enum logic [1:0] {
    RD_HI,
    RD_J,
    RD_NXT
  } rd_sel_t;

  // Key memory write source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_LOAD,
    WR_J_RDATA,
    WR_NXT_TMP,
    WR_HI_RDATA,
    WR_NXT_PIVOT
  } wr_sel_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    init;
    logic    part_init;
    logic    piv_ld;
    logic    tmp_ld;
    logic    j_inc;
    logic    nxt_inc;
    logic    push_l;
    logic    push_r;
    logic    pop_rd;
    logic    pop_ld;
    logic    emit_init;
    logic    emit;
    logic    clear;
  } cmd_t;

  typedef struct packed {
    logic single;
    logic lt;
    logic nxt_eq_j;
    logic j_eq_hi;
    logic push_l_ok;
    logic push_r_ok;
    logic sp_zero;
    logic emit_end;
    logic part_only;
  } status_t;

endpackage

// File: sv/qle_datapath.sv
module qle_datapath (
  input  logic              clk,
  input  logic              rst,
  input  qle_pkg::cmd_t     cmd,
  output qle_pkg::status_t  status,
  input  qle_pkg::in_item_t item,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  output logic              strobe,
  output qle_pkg::out_item_t result
);

  logic signed [qle_pkg::KEY_W-1:0] kmem [qle_pkg::MAX_KEYS];
  logic signed [qle_pkg::KEY_W-1:0] krd;
  logic signed [qle_pkg::KEY_W-1:0] pivot;
  logic signed [qle_pkg::KEY_W-1:0] tmp;
  logic signed [qle_pkg::KEY_W-1:0] kwd;
  qle_pkg::range_t smem [qle_pkg::MAX_KEYS];
  qle_pkg::range_t srd;
  qle_pkg::range_t swd;
  qle_pkg::idx_t   kwa;
  qle_pkg::idx_t   kra;
  qle_pkg::idx_t   lo;
  qle_pkg::idx_t   hi;
  qle_pkg::idx_t   j;
  qle_pkg::idx_t   nxt;
  qle_pkg::idx_t   last_idx;
  qle_pkg::cnt_t   count;
  qle_pkg::cnt_t   sp;
  logic            full;
  logic            kwe;
  logic            part_only;
  logic            emit_last;
  logic [qle_pkg::IDX_W:0] nxt_w;
  logic [qle_pkg::IDX_W:0] lo_w;
  logic [qle_pkg::IDX_W:0] hi_w;

  assign full     = (count >= qle_pkg::CNT_W'(qle_pkg::MAX_KEYS));
  assign last_idx = qle_pkg::IDX_W'(count - qle_pkg::CNT_W'(1));
  assign nxt_w    = {1'b0, nxt};
  assign lo_w     = {1'b0, lo};
  assign hi_w     = {1'b0, hi};

  // Select key memory read address
  always_comb begin
    unique case (cmd.rd_sel)
      qle_pkg::RD_HI:  kra = hi;
      qle_pkg::RD_J:   kra = j;
      qle_pkg::RD_NXT: kra = nxt;
      default:         kra = j;
    endcase
  end

  // Select key memory write address and data
  always_comb begin
    kwe = 1'b1;
    kwa = j;
    kwd = krd;
    unique case (cmd.wr_sel)
      qle_pkg::WR_LOAD: begin
        kwe = !full;
        kwa = count[qle_pkg::IDX_W-1:0];
        kwd = item.key;
      end
      qle_pkg::WR_J_RDATA: begin
        kwa = j;
        kwd = krd;
      end
      qle_pkg::WR_NXT_TMP: begin
        kwa = nxt;
        kwd = tmp;
      end
      qle_pkg::WR_HI_RDATA: begin
        kwa = hi;
        kwd = krd;
      end
      qle_pkg::WR_NXT_PIVOT: begin
        kwa = nxt;
        kwd = pivot;
      end
      default: kwe = 1'b0;
    endcase
  end

  // Key memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (kwe) begin
      kmem[kwa] <= kwd;
    end
    krd <= kmem[kra];
  end

  // Range stack memory
  always_comb begin
    if (cmd.push_l) begin
      swd.lo = lo;
      swd.hi = nxt - qle_pkg::IDX_W'(1);
    end else begin
      swd.lo = nxt + qle_pkg::IDX_W'(1);
      swd.hi = hi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_l || cmd.push_r) begin
      smem[sp[qle_pkg::IDX_W-1:0]] <= swd;
    end
    srd <= smem[qle_pkg::IDX_W'(sp - qle_pkg::CNT_W'(1))];
  end

  // Control registers: count, stack pointer, mode, output strobe and last flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sp        <= '0;
      part_only <= 1'b0;
      strobe    <= 1'b0;
      emit_last <= 1'b0;
    end else begin
      if (cfg_valid) begin
        part_only <= cfg_data;
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.wr_sel == qle_pkg::WR_LOAD && !full) begin
        count <= count + qle_pkg::CNT_W'(1);
      end
      if (cmd.push_l || cmd.push_r) begin
        sp <= sp + qle_pkg::CNT_W'(1);
      end else if (cmd.pop_rd) begin
        sp <= sp - qle_pkg::CNT_W'(1);
      end
      strobe    <= cmd.emit;
      emit_last <= cmd.emit && (j == last_idx);
    end
  end

  // Index and key working registers
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      lo <= '0;
      hi <= last_idx;
    end else if (cmd.pop_ld) begin
      lo <= srd.lo;
      hi <= srd.hi;
    end
    if (cmd.part_init) begin
      j   <= lo;
      nxt <= lo;
    end else begin
      if (cmd.emit_init) begin
        j <= '0;
      end else if (cmd.j_inc || cmd.emit) begin
        j <= j + qle_pkg::IDX_W'(1);
      end
      if (cmd.nxt_inc) begin
        nxt <= nxt + qle_pkg::IDX_W'(1);
      end
    end
    if (cmd.piv_ld) begin
      pivot <= krd;
    end
    if (cmd.tmp_ld) begin
      tmp <= krd;
    end
  end

  // Status back to the controller
  assign status.single    = (count == qle_pkg::CNT_W'(1));
  assign status.lt        = ($signed(krd) < $signed(pivot));
  assign status.nxt_eq_j  = (nxt == j);
  assign status.j_eq_hi   = (j == hi);
  assign status.push_l_ok = (nxt_w > lo_w + (qle_pkg::IDX_W+1)'(1));
  assign status.push_r_ok = (nxt_w + (qle_pkg::IDX_W+1)'(1) < hi_w);
  assign status.sp_zero   = (sp == '0);
  assign status.emit_end  = (j == last_idx);
  assign status.part_only = part_only;

  assign result.key_out  = krd;
  assign result.last_out = emit_last;

endmodule

// File: sv/qle_controller.sv
module qle_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last,
  input  qle_pkg::status_t status,
  output qle_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_PIV,
    S_PIV_LD,
    S_SCAN,
    S_CMP,
    S_SWAP_A,
    S_SWAP_B,
    S_FIN_A,
    S_FIN_B,
    S_PUSH_L,
    S_PUSH_R,
    S_POP,
    S_POP_LD,
    S_EMIT_INIT,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = qle_pkg::RD_J;
    cmd.wr_sel = qle_pkg::WR_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.wr_sel = qle_pkg::WR_LOAD;
          if (last) begin
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.init   = 1'b1;
        state_next = status.single ? S_EMIT_INIT : S_PIV;
      end
      S_PIV: begin
        cmd.rd_sel    = qle_pkg::RD_HI;
        cmd.part_init = 1'b1;
        state_next    = S_PIV_LD;
      end
      S_PIV_LD: begin
        cmd.piv_ld = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (status.j_eq_hi) begin
          cmd.rd_sel = qle_pkg::RD_NXT;
          state_next = S_FIN_A;
        end else begin
          cmd.rd_sel = qle_pkg::RD_J;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (status.lt && status.nxt_eq_j) begin
          cmd.j_inc   = 1'b1;
          cmd.nxt_inc = 1'b1;
          state_next  = S_SCAN;
        end else if (status.lt) begin
          cmd.tmp_ld = 1'b1;
          cmd.rd_sel = qle_pkg::RD_NXT;
          state_next = S_SWAP_A;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SWAP_A: begin
        cmd.wr_sel = qle_pkg::WR_J_RDATA;
        state_next = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.wr_sel  = qle_pkg::WR_NXT_TMP;
        cmd.j_inc   = 1'b1;
        cmd.nxt_inc = 1'b1;
        state_next  = S_SCAN;
      end
      S_FIN_A: begin
        cmd.wr_sel = qle_pkg::WR_HI_RDATA;
        state_next = S_FIN_B;
      end
      S_FIN_B: begin
        cmd.wr_sel = qle_pkg::WR_NXT_PIVOT;
        state_next = status.part_only ? S_EMIT_INIT : S_PUSH_L;
      end
      S_PUSH_L: begin
        cmd.push_l = status.push_l_ok;
        state_next = S_PUSH_R;
      end
      S_PUSH_R: begin
        cmd.push_r = status.push_r_ok;
        state_next = S_POP;
      end
      S_POP: begin
        if (status.sp_zero) begin
          state_next = S_EMIT_INIT;
        end else begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP_LD;
        end
      end
      S_POP_LD: begin
        cmd.pop_ld = 1'b1;
        state_next = S_PIV;
      end
      S_EMIT_INIT: begin
        cmd.emit_init = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        cmd.rd_sel = qle_pkg::RD_J;
        cmd.emit   = 1'b1;
        if (status.emit_end) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and busy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// File: sv/quicksort_lomuto_engine.sv
// Loading: one key item a cycle; a non-final item leaves busy low. A lone key goes straight to emission.
// After the last key each Lomuto pass reads its pivot and scans its range. In full sort each range
// adds stack work (push left, push right, pop); in partition mode one pass leads to emission.
// The key memory does one read and one write a cycle. Emission: n results on consecutive cycles,
// no stall. Sync reset clears count, stack pointer and mode (full sort); key memory is not cleared.
module quicksort_lomuto_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  qle_pkg::in_item_t  item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  output logic               strobe,
  output qle_pkg::out_item_t result
);

  qle_pkg::cmd_t    cmd;
  qle_pkg::status_t status;

  // Take configuration at any time; the user must write it only while idle (not enforced)
  assign cfg_ready = 1'b1;

  qle_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start && !busy),
    .last   (item.last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  qle_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item      (item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

// File: sv/qle_checker.sv
`include "quicksort_lomuto_engine_assert.svh"

module qle_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input qle_pkg::in_item_t  item,
  input logic               strobe,
  input qle_pkg::out_item_t result
);

  // A final key always starts processing
  `QLE_ASSERT_NEXT(a_last_goes_busy, clk, rst, start && !busy && item.last, busy, "final key did not start processing")
  // A non-final key is absorbed without setting busy
  `QLE_ASSERT_NEXT(a_load_one_cycle, clk, rst, start && !busy && !item.last, !busy, "non-final key held the engine busy")
  // Emission is a single unbroken burst
  `QLE_ASSERT_NEXT(a_burst_contiguous, clk, rst, strobe && !result.last_out, strobe, "gap inside result burst")
  // Nothing follows the final result
  `QLE_ASSERT_NEXT(a_burst_ends, clk, rst, strobe && result.last_out, !strobe, "result after final item")
  // No result while an input key is being taken and busy was low before as well
  `QLE_ASSERT_NOW(a_no_emit_on_load, clk, rst, start && !busy && $past(!busy), !strobe, "result during load")

endmodule

bind quicksort_lomuto_engine qle_checker u_qle_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .strobe (strobe),
  .result (result)
);

// File: bench/tb_top.sv
module tb_top;

  localparam int QUIET_LIMIT   = 40000;
  localparam int SETTLE_CYCLES = 16;

  localparam logic signed [qle_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [qle_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_DUPES,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_EXTREME
  } key_shape_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  qle_pkg::in_item_t  item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;
  logic               strobe;
  qle_pkg::out_item_t result;

  // Shadow of the engine: held keys, mode and the keys still due out
  logic signed [qle_pkg::KEY_W-1:0] held_keys [qle_pkg::MAX_KEYS];
  int                 held_count;
  logic               part_mode;
  qle_pkg::out_item_t due_keys [$];
  int                 mismatches = 0;
  int                 quiet_cycles;
  int                 idle_pct;

  always #5 clk = ~clk;

  quicksort_lomuto_engine dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .result    (result)
  );

  // Split [lo, hi] around its last key; keys strictly below the pivot go low
  function automatic int lomuto_split(int lo, int hi);
    logic signed [qle_pkg::KEY_W-1:0] pivot;
    logic signed [qle_pkg::KEY_W-1:0] tmp;
    int nxt;
    pivot = held_keys[hi];
    nxt   = lo;
    for (int j = lo; j < hi; j++) begin
      if (held_keys[j] < pivot) begin
        tmp            = held_keys[nxt];
        held_keys[nxt] = held_keys[j];
        held_keys[j]   = tmp;
        nxt++;
      end
    end
    tmp            = held_keys[nxt];
    held_keys[nxt] = held_keys[hi];
    held_keys[hi]  = tmp;
    return nxt;
  endfunction

  // Full quicksort with pending ranges on an explicit stack
  function automatic void sort_held_keys();
    int range_lo [qle_pkg::MAX_KEYS];
    int range_hi [qle_pkg::MAX_KEYS];
    int depth;
    int lo;
    int hi;
    int mid;
    depth = 0;
    if (held_count > 1) begin
      range_lo[0] = 0;
      range_hi[0] = held_count - 1;
      depth = 1;
    end
    while (depth > 0) begin
      depth--;
      lo  = range_lo[depth];
      hi  = range_hi[depth];
      mid = lomuto_split(lo, hi);
      if (mid - 1 > lo) begin
        range_lo[depth] = lo;
        range_hi[depth] = mid - 1;
        depth++;
      end
      if (hi > mid + 1) begin
        range_lo[depth] = mid + 1;
        range_hi[depth] = hi;
        depth++;
      end
    end
  endfunction

  // Store a key; on the last, sort or partition per mode and queue the set to check
  function automatic void take_key(qle_pkg::in_item_t it);
    if (held_count < qle_pkg::MAX_KEYS) begin
      held_keys[held_count] = it.key;
      held_count++;
    end
    if (it.last) begin
      if (part_mode) begin
        if (held_count > 0) void'(lomuto_split(0, held_count - 1));
      end else begin
        sort_held_keys();
      end
      for (int i = 0; i < held_count; i++)
        due_keys.push_back('{key_out: held_keys[i], last_out: (i == held_count - 1)});
      held_count = 0;
    end
  endfunction

  // Track accepted items and register writes, then check each strobed key
  always @(posedge clk) begin : key_check
    qle_pkg::out_item_t want;
    if (rst) begin
      held_count = 0;
      part_mode  = 1'b0;
      due_keys.delete();
    end else begin
      if (cfg_valid && cfg_ready) part_mode = cfg_data;
      if (start && !busy) take_key(item);
      if (strobe) begin
        if (due_keys.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected key: expected none, got key_out=%0d last_out=%0b",
                   $time, result.key_out, result.last_out);
        end else begin
          want = due_keys.pop_front();
          if (result.key_out !== want.key_out) begin
            mismatches++;
            $display("%0t: key_out mismatch: expected %0d, got %0d",
                     $time, want.key_out, result.key_out);
          end
          if (result.last_out !== want.last_out) begin
            mismatches++;
            $display("%0t: last_out mismatch: expected %0b, got %0b",
                     $time, want.last_out, result.last_out);
          end
        end
      end
    end
  end

  // Stop the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL quicksort_lomuto_engine");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, idling first at random, and hold it until taken
  task automatic send_item(logic signed [qle_pkg::KEY_W-1:0] k, logic lst);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= '{key: k, last: lst};
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every expected key has come and the engine has settled
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (due_keys.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic part_only);
    cfg_valid <= 1'b1;
    cfg_data  <= part_only;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_set(int n, key_shape_t shape);
    logic signed [qle_pkg::KEY_W-1:0] k;
    int base;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_RANDOM:  k = $urandom;
        SHAPE_DUPES:   k = $urandom_range(6) - 3;
        SHAPE_RISING:  k = base + i;
        SHAPE_FALLING: k = base - i;
        default: begin
          case ($urandom_range(3))
            0:       k = KEY_MIN;
            1:       k = KEY_MAX;
            2:       k = 0;
            default: k = -1;
          endcase
        end
      endcase
      send_item(k, i == n - 1);
    end
  endtask

  // Full sort: single key, sign extremes, duplicates, mixed order
  task automatic test_full_sort_directed();
    write_mode(1'b0);
    idle_pct = 0;
    send_item(KEY_MAX, 1'b1);
    send_item(KEY_MAX, 1'b0);
    send_item(KEY_MIN, 1'b1);
    send_item(KEY_MAX, 1'b0);
    send_item(KEY_MIN, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(KEY_MIN, 1'b1);
    send_item(7, 1'b0);
    send_item(7, 1'b0);
    send_item(7, 1'b1);
    send_item(3, 1'b0);
    send_item(-5, 1'b0);
    send_item(3, 1'b0);
    send_item(100, 1'b0);
    send_item(-5, 1'b1);
    wait_drained();
  endtask

  // Single partition: single key, pivot in the middle, extremes
  task automatic test_partition_directed();
    write_mode(1'b1);
    idle_pct = 0;
    send_item(KEY_MIN, 1'b1);
    send_item(4, 1'b0);
    send_item(9, 1'b0);
    send_item(-2, 1'b0);
    send_item(1, 1'b0);
    send_item(5, 1'b0);
    send_item(0, 1'b0);
    send_item(3, 1'b1);
    send_item(KEY_MAX, 1'b0);
    send_item(KEY_MIN, 1'b1);
    wait_drained();
  endtask

  // Overfill the store: the extra keys are dropped, the closing one still ends the set
  task automatic test_store_full();
    write_mode(1'b0);
    idle_pct = 0;
    send_set(qle_pkg::MAX_KEYS + 2, SHAPE_RANDOM);
    wait_drained();
  endtask

  // Random sets, mostly small, with an occasional pause until all keys are out
  task automatic test_random_sets(logic part_only, int pct, int budget);
    int sent;
    int n;
    write_mode(part_only);
    idle_pct = pct;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(19) == 0) n = $urandom_range(qle_pkg::MAX_KEYS / 2, qle_pkg::MAX_KEYS);
      else n = $urandom_range(1, 10);
      if ($urandom_range(9) == 0) wait_drained();
      send_set(n, key_shape_t'($urandom_range(SHAPE_EXTREME)));
      sent += n;
    end
    wait_drained();
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    idle_pct  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_full_sort_directed();
    test_partition_directed();
    test_store_full();
    test_random_sets(1'b0, 0, 80);
    test_random_sets(1'b1, 47, 80);
    test_random_sets(1'b0, 7, 80);
    test_random_sets(1'b1, 0, 80);

    wait_drained();
    if (mismatches == 0 && due_keys.size() == 0) begin
      $display("PASS quicksort_lomuto_engine");
    end else begin
      $display("FAIL quicksort_lomuto_engine");
    end
    $finish;
  end

endmodule
